/* rtl/rfo_pkg.sv */
`timescale 1ns / 1ps

package rfo_pkg;

    // Default geometry of the character store
    localparam int DEF_MAX_COLS  = 512;
    localparam int DEF_MAX_ROWS  = 512;
    localparam int DEF_FRAC_BITS = 8;

    // Field widths fixed by the item format
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 8;
    localparam int COORD_W    = 24;
    localparam int CODE_W     = 8;
    localparam int RC_W       = 9;
    localparam int STATUS_W   = 2;
    localparam int DIM_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Rectangle kinds
    localparam logic [KIND_W-1:0] KIND_FILLED  = 8'h52;
    localparam logic [KIND_W-1:0] KIND_OUTLINE = 8'h72;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_WIDTH      = 10'd1;
    localparam logic [DIM_W-1:0]  RST_HEIGHT     = 10'd1;
    localparam logic [CODE_W-1:0] RST_BACKGROUND = 8'd32;

endpackage

/* rtl/rfo_ifs.sv */
`timescale 1ns / 1ps

interface rfo_cmd_if;
    logic                                      valid;
    logic                                      ready;
    logic        [rfo_pkg::MODE_W-1:0]         mode;
    logic        [rfo_pkg::KIND_W-1:0]         kind;
    logic signed [rfo_pkg::COORD_W-1:0]        left;
    logic signed [rfo_pkg::COORD_W-1:0]        top;
    logic signed [rfo_pkg::COORD_W-1:0]        size_x;
    logic signed [rfo_pkg::COORD_W-1:0]        size_y;
    logic        [rfo_pkg::CODE_W-1:0]         fill_code;
    logic        [rfo_pkg::RC_W-1:0]           read_col;
    logic        [rfo_pkg::RC_W-1:0]           read_row;

    modport source (
        output valid, mode, kind, left, top, size_x, size_y, fill_code, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, mode, kind, left, top, size_x, size_y, fill_code, read_col, read_row,
        output ready
    );
endinterface

interface rfo_res_if;
    logic                             valid;
    logic                             ready;
    logic [rfo_pkg::STATUS_W-1:0]     status;
    logic [rfo_pkg::CODE_W-1:0]       pixel;

    modport source (output valid, status, pixel, input ready);
    modport sink   (input valid, status, pixel, output ready);
endinterface

interface rfo_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rfo_pkg::CFG_IDX_W-1:0]     index;
    logic [rfo_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rectangle_fill_outline_rasterizer_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// i_cmd     in   valid/ready   mode, kind, left, top, size_x, size_y, fill_code, read_col, read_row
// o_res     out  valid/ready   status, pixel
// i_cfg     in   valid/ready   index, data (width, height, background)
//
// Clear and accepted draw: the sweep writes at most one pixel per
// cycle and covers the whole active area.
// Read: passes through a read state that waits for the registered read of the frame store.
// Rejected draw, empty area, read outside or unused mode: go straight from idle to finish.
// Reset is synchronous and clears control state and registers, not the frame store.
// A stalled result holds in the output register; one further item is taken and waits.

module rectangle_fill_outline_rasterizer_unit #(
    parameter int MAX_COLS  = rfo_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS  = rfo_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = rfo_pkg::DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfo_cmd_if.sink   i_cmd,
    rfo_res_if.source o_res,
    rfo_cfg_if.sink   i_cfg
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = $clog2(MAX_COLS + 1);
    localparam int YW     = $clog2(MAX_ROWS + 1);
    localparam int AXW    = (XW > rfo_pkg::DIM_W) ? XW : rfo_pkg::DIM_W;
    localparam int AYW    = (YW > rfo_pkg::DIM_W) ? YW : rfo_pkg::DIM_W;
    localparam int RXW    = (XW > rfo_pkg::RC_W) ? XW : rfo_pkg::RC_W;
    localparam int RYW    = (YW > rfo_pkg::RC_W) ? YW : rfo_pkg::RC_W;
    localparam int PW     = ((XW > YW) ? XW : YW) + FRAC_BITS + 1;
    localparam int CMP_W  = (PW > rfo_pkg::COORD_W + 2) ? PW : rfo_pkg::COORD_W + 2;
    localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_READ, S_FINISH} t_state;

    t_state r_state;

    // Configuration registers
    logic [rfo_pkg::DIM_W-1:0]  r_width;
    logic [rfo_pkg::DIM_W-1:0]  r_height;
    logic [rfo_pkg::CODE_W-1:0] r_background;

    // Work registers
    logic [XW-1:0]                   r_x;
    logic [YW-1:0]                   r_y;
    logic [AW-1:0]                   r_addr;
    logic [AW-1:0]                   r_row_base;
    logic [AW-1:0]                   r_raddr;
    logic                            r_clear;
    logic                            r_filled;
    logic                            r_is_read;
    logic [rfo_pkg::CODE_W-1:0]      r_code;
    logic [rfo_pkg::STATUS_W-1:0]    r_status;
    logic signed [CMP_W-1:0]         r_lo_x;
    logic signed [CMP_W-1:0]         r_hi_x;
    logic signed [CMP_W-1:0]         r_lo_x1;
    logic signed [CMP_W-1:0]         r_hi_x1;
    logic signed [CMP_W-1:0]         r_lo_y;
    logic signed [CMP_W-1:0]         r_hi_y;
    logic signed [CMP_W-1:0]         r_lo_y1;
    logic signed [CMP_W-1:0]         r_hi_y1;

    // Output register
    logic                            r_out_valid;
    logic [rfo_pkg::STATUS_W-1:0]    r_out_status;
    logic [rfo_pkg::CODE_W-1:0]      r_out_pixel;

    logic [AXW-1:0]                  w_cols_full;
    logic [AYW-1:0]                  w_rows_full;
    logic [XW-1:0]                   w_cols;
    logic [YW-1:0]                   w_rows;
    logic                            w_empty;
    logic                            w_accept;
    logic                            w_bad_rect;
    logic                            w_read_out;
    logic signed [CMP_W-1:0]         w_fx;
    logic signed [CMP_W-1:0]         w_fy;
    logic                            w_in_x;
    logic                            w_in_y;
    logic                            w_int_x;
    logic                            w_int_y;
    logic                            w_we;
    logic                            w_last_x;
    logic                            w_last_y;
    logic                            w_out_free;
    logic                            w_load;
    logic [rfo_pkg::CODE_W-1:0]      w_rdata;

    // Saturate the active area to the store geometry
    assign w_cols_full = (AXW'(r_width) > AXW'(MAX_COLS)) ? AXW'(MAX_COLS) : AXW'(r_width);
    assign w_rows_full = (AYW'(r_height) > AYW'(MAX_ROWS)) ? AYW'(MAX_ROWS) : AYW'(r_height);
    assign w_cols      = XW'(w_cols_full);
    assign w_rows      = YW'(w_rows_full);
    assign w_empty     = (w_cols == '0) || (w_rows == '0);

    // Handshakes
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.pixel  = r_out_pixel;
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_load       = (r_state == S_FINISH) && w_out_free;

    // Classify the incoming item
    assign w_bad_rect = i_cmd.size_x[rfo_pkg::COORD_W-1] || (i_cmd.size_x == '0) ||
                        i_cmd.size_y[rfo_pkg::COORD_W-1] || (i_cmd.size_y == '0) ||
                        ((i_cmd.kind != rfo_pkg::KIND_FILLED) &&
                         (i_cmd.kind != rfo_pkg::KIND_OUTLINE));
    assign w_read_out = (RXW'(i_cmd.read_col) >= RXW'(w_cols)) ||
                        (RYW'(i_cmd.read_row) >= RYW'(w_rows));

    // Pixel coverage at the sweep position
    assign w_fx    = $signed(CMP_W'(r_x) << FRAC_BITS);
    assign w_fy    = $signed(CMP_W'(r_y) << FRAC_BITS);
    assign w_in_x  = (w_fx >= r_lo_x) && (w_fx <= r_hi_x);
    assign w_in_y  = (w_fy >= r_lo_y) && (w_fy <= r_hi_y);
    assign w_int_x = (w_fx >= r_lo_x1) && (w_fx <= r_hi_x1);
    assign w_int_y = (w_fy >= r_lo_y1) && (w_fy <= r_hi_y1);
    assign w_we    = (r_state == S_SWEEP) &&
                     (r_clear || (w_in_x && w_in_y && (r_filled || !(w_int_x && w_int_y))));
    assign w_last_x = (r_x == w_cols - XW'(1));
    assign w_last_y = (r_y == w_rows - YW'(1));

    // Frame store
    rfo_ram #(
        .WIDTH (rfo_pkg::CODE_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (r_code),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= rfo_pkg::RST_WIDTH;
            r_height     <= rfo_pkg::RST_HEIGHT;
            r_background <= rfo_pkg::RST_BACKGROUND;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                rfo_pkg::REG_WIDTH:      r_width      <= i_cfg.data;
                rfo_pkg::REG_HEIGHT:     r_height     <= i_cfg.data;
                rfo_pkg::REG_BACKGROUND: r_background <= i_cfg.data[rfo_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: accept, sweep the area, read, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_is_read   <= 1'b0;
        end else begin
            // Load a finished result, else drop a taken one
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x        <= '0;
                        r_y        <= '0;
                        r_addr     <= '0;
                        r_row_base <= '0;
                        r_status   <= ((i_cmd.mode == rfo_pkg::MODE_DRAW) && w_bad_rect) ?
                                      rfo_pkg::ST_REJECT :
                                      ((i_cmd.mode == rfo_pkg::MODE_READ) && w_read_out) ?
                                      rfo_pkg::ST_OUTSIDE : rfo_pkg::ST_OK;
                        r_is_read  <= (i_cmd.mode == rfo_pkg::MODE_READ) && !w_read_out;
                        r_clear    <= (i_cmd.mode == rfo_pkg::MODE_CLEAR);
                        r_filled   <= (i_cmd.kind == rfo_pkg::KIND_FILLED);
                        r_code     <= (i_cmd.mode == rfo_pkg::MODE_CLEAR) ? r_background :
                                      i_cmd.fill_code;
                        r_lo_x     <= CMP_W'(i_cmd.left);
                        r_hi_x     <= CMP_W'(i_cmd.left) + CMP_W'(i_cmd.size_x);
                        r_lo_x1    <= CMP_W'(i_cmd.left) + ONE;
                        r_hi_x1    <= CMP_W'(i_cmd.left) + CMP_W'(i_cmd.size_x) - ONE;
                        r_lo_y     <= CMP_W'(i_cmd.top);
                        r_hi_y     <= CMP_W'(i_cmd.top) + CMP_W'(i_cmd.size_y);
                        r_lo_y1    <= CMP_W'(i_cmd.top) + ONE;
                        r_hi_y1    <= CMP_W'(i_cmd.top) + CMP_W'(i_cmd.size_y) - ONE;
                        r_raddr    <= AW'(i_cmd.read_row) * AW'(MAX_COLS) +
                                      AW'(i_cmd.read_col);
                        unique case (i_cmd.mode)
                            rfo_pkg::MODE_CLEAR: begin
                                r_state <= w_empty ? S_FINISH : S_SWEEP;
                            end
                            rfo_pkg::MODE_DRAW: begin
                                r_state <= (w_bad_rect || w_empty) ? S_FINISH : S_SWEEP;
                            end
                            rfo_pkg::MODE_READ: begin
                                r_state <= w_read_out ? S_FINISH : S_READ;
                            end
                            default: r_state <= S_FINISH;
                        endcase
                    end
                end
                S_SWEEP: begin
                    // Advance along the row, then to the next row
                    if (w_last_x) begin
                        r_x <= '0;
                        if (w_last_y) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_y        <= r_y + YW'(1);
                            r_row_base <= r_row_base + AW'(MAX_COLS);
                            r_addr     <= r_row_base + AW'(MAX_COLS);
                        end
                    end else begin
                        r_x    <= r_x + XW'(1);
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // Load the result once the output register is free
                    if (w_load) begin
                        r_out_status <= r_status;
                        r_out_pixel  <= r_is_read ? w_rdata : '0;
                        r_is_read    <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Store writes come only from the sweep
    a_we_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SWEEP))
        else $error("frame store written outside the sweep");

    // Sweep position stays in the active area
    a_sweep_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((r_x < w_cols) && (r_y < w_rows)))
        else $error("sweep position outside active area");

    // Write address tracks the sweep position
    a_sweep_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_addr == r_row_base + AW'(r_x)))
        else $error("sweep address out of step");

    // A new result is loaded only from the finish state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_FINISH))
        else $error("result appeared without finishing an item");

    // Non-ok results carry a zero pixel
    a_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != rfo_pkg::ST_OK)) |-> (r_out_pixel == '0))
        else $error("pixel not zero on a failed item");

endmodule

/* rtl/rfo_ram.sv */
`timescale 1ns / 1ps

module rfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* tb/tb_rectangle_fill_outline_rasterizer_unit.sv */
`timescale 1ns / 1ps

module tb_rectangle_fill_outline_rasterizer_unit;

    localparam int TB_COLS     = rfo_pkg::DEF_MAX_COLS;
    localparam int TB_ROWS     = rfo_pkg::DEF_MAX_ROWS;
    localparam int TB_FRAC     = rfo_pkg::DEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 50;
    localparam int PRINT_CAP   = 60;
    localparam int N_PHASES    = 7;
    // Mode with no function: the block answers ok and does nothing
    localparam logic [rfo_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [rfo_pkg::MODE_W-1:0]  mode;
        logic [rfo_pkg::KIND_W-1:0]  kind;
        logic [rfo_pkg::COORD_W-1:0] left;
        logic [rfo_pkg::COORD_W-1:0] top;
        logic [rfo_pkg::COORD_W-1:0] size_x;
        logic [rfo_pkg::COORD_W-1:0] size_y;
        logic [rfo_pkg::CODE_W-1:0]  fill_code;
        logic [rfo_pkg::RC_W-1:0]    read_col;
        logic [rfo_pkg::RC_W-1:0]    read_row;
    } t_rect_cmd;

    typedef struct packed {
        logic [rfo_pkg::STATUS_W-1:0] status;
        logic [rfo_pkg::CODE_W-1:0]   pixel;
    } t_pix_res;

    typedef struct packed {
        logic                           is_cfg;
        logic [rfo_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [rfo_pkg::CFG_DATA_W-1:0] reg_data;
        t_rect_cmd                      item;
        logic                           fixed;
        t_pix_res                       typed;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rfo_cmd_if cmd_ch ();
    rfo_res_if res_ch ();
    rfo_cfg_if cfg_ch ();

    rectangle_fill_outline_rasterizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the character store and the registers
    bit   [rfo_pkg::CODE_W-1:0] frame_copy [TB_COLS*TB_ROWS];
    logic [rfo_pkg::DIM_W-1:0]  cfg_width  = rfo_pkg::RST_WIDTH;
    logic [rfo_pkg::DIM_W-1:0]  cfg_height = rfo_pkg::RST_HEIGHT;
    logic [rfo_pkg::CODE_W-1:0] cfg_bg     = rfo_pkg::RST_BACKGROUND;

    t_pix_res  expected_results [$];
    t_stim_row directed_rows [$];
    int        fail_count     = 0;
    int        cycle_count    = 0;
    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;

    // Random phases: geometry, background, idling and item count
    int phase_cols [N_PHASES] = '{16, 1, 3, 1023, 9, 0, 512};
    int phase_rows [N_PHASES] = '{12, 1, 17, 2, 1023, 7, 512};
    int phase_bg   [N_PHASES] = '{8'h00, 8'hFF, 8'h2E, 8'h80, 8'h7F, 8'h41, 8'h01};
    int phase_send [N_PHASES] = '{0, 45, 0, 35, 35, 0, 0};
    int phase_recv [N_PHASES] = '{0, 0, 45, 35, 35, 0, 45};
    int phase_len  [N_PHASES] = '{15, 10, 10, 10, 8, 6, 8};

    // Clock: 2 ns period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic int clamp_extent(input logic [rfo_pkg::DIM_W-1:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Work out the result of one item and update the shadow store
    function automatic t_pix_res predict_result(input t_rect_cmd c);
        t_pix_res r;
        int       cols, rows;
        longint   one, lx, ty, rx, by, fx, fy;
        bit       interior;
        r    = '0;
        cols = clamp_extent(cfg_width, TB_COLS);
        rows = clamp_extent(cfg_height, TB_ROWS);
        one  = longint'(1) << TB_FRAC;
        case (c.mode)
            rfo_pkg::MODE_CLEAR: begin
                for (int y = 0; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        frame_copy[y*TB_COLS + x] = cfg_bg;
            end
            rfo_pkg::MODE_DRAW: begin
                lx = longint'($signed(c.left));
                ty = longint'($signed(c.top));
                rx = lx + longint'($signed(c.size_x));
                by = ty + longint'($signed(c.size_y));
                if ($signed(c.size_x) <= 0 || $signed(c.size_y) <= 0 ||
                    (c.kind != rfo_pkg::KIND_FILLED && c.kind != rfo_pkg::KIND_OUTLINE)) begin
                    r.status = rfo_pkg::ST_REJECT;
                end else begin
                    for (int y = 0; y < rows; y++) begin
                        fy = longint'(y) * one;
                        if (fy < ty || fy > by)
                            continue;
                        for (int x = 0; x < cols; x++) begin
                            fx = longint'(x) * one;
                            if (fx < lx || fx > rx)
                                continue;
                            interior = (fx - one >= lx) && (fx + one <= rx) &&
                                       (fy - one >= ty) && (fy + one <= by);
                            if (c.kind == rfo_pkg::KIND_FILLED || !interior)
                                frame_copy[y*TB_COLS + x] = c.fill_code;
                        end
                    end
                end
            end
            rfo_pkg::MODE_READ: begin
                if (int'(c.read_col) >= cols || int'(c.read_row) >= rows)
                    r.status = rfo_pkg::ST_OUTSIDE;
                else
                    r.pixel = frame_copy[int'(c.read_row)*TB_COLS + int'(c.read_col)];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random item shaped to the active area; heavy items sweep the whole area
    function automatic t_rect_cmd make_item(input int cols, input int rows,
                                            input bit heavy_ok);
        t_rect_cmd c;
        int        pick, ext_x, ext_y, defect;
        c.mode      = rfo_pkg::MODE_W'($urandom);
        c.kind      = rfo_pkg::KIND_W'($urandom);
        c.left      = rfo_pkg::COORD_W'($urandom);
        c.top       = rfo_pkg::COORD_W'($urandom);
        c.size_x    = rfo_pkg::COORD_W'($urandom);
        c.size_y    = rfo_pkg::COORD_W'($urandom);
        c.fill_code = rfo_pkg::CODE_W'($urandom);
        c.read_col  = rfo_pkg::RC_W'($urandom);
        c.read_row  = rfo_pkg::RC_W'($urandom);
        ext_x = (cols == 0) ? 8 : cols;
        ext_y = (rows == 0) ? 8 : rows;
        pick  = heavy_ok ? int'($urandom_range(99)) : 55 + int'($urandom_range(44));
        if (pick < 10) begin
            c.mode = rfo_pkg::MODE_CLEAR;
        end else if (pick < 68) begin
            // well-formed rectangle, broken afterwards for the reject share
            c.mode = rfo_pkg::MODE_DRAW;
            c.kind = ($urandom_range(1) == 0) ? rfo_pkg::KIND_FILLED : rfo_pkg::KIND_OUTLINE;
            if ($urandom_range(9) != 0) begin
                c.left   = rfo_pkg::COORD_W'(int'($urandom_range((ext_x + 6) * 256)) - 3 * 256);
                c.top    = rfo_pkg::COORD_W'(int'($urandom_range((ext_y + 6) * 256)) - 3 * 256);
                c.size_x = rfo_pkg::COORD_W'($urandom_range((ext_x + 3) * 256, 1));
                c.size_y = rfo_pkg::COORD_W'($urandom_range((ext_y + 3) * 256, 1));
            end else begin
                c.size_x = rfo_pkg::COORD_W'($urandom_range(24'h7FFFFF, 1));
                c.size_y = rfo_pkg::COORD_W'($urandom_range(24'h7FFFFF, 1));
            end
            if (pick >= 55) begin
                defect = $urandom_range(2);
                if (defect == 0)
                    c.size_x = rfo_pkg::COORD_W'(-int'($urandom_range(24'h800000)));
                else if (defect == 1)
                    c.size_y = rfo_pkg::COORD_W'(-int'($urandom_range(24'h800000)));
                else
                    while (c.kind == rfo_pkg::KIND_FILLED || c.kind == rfo_pkg::KIND_OUTLINE)
                        c.kind = rfo_pkg::KIND_W'($urandom);
            end
        end else if (pick < 95) begin
            c.mode = rfo_pkg::MODE_READ;
            if (cols > 0 && rows > 0 && $urandom_range(3) != 0) begin
                c.read_col = rfo_pkg::RC_W'($urandom_range(cols - 1));
                c.read_row = rfo_pkg::RC_W'($urandom_range(rows - 1));
            end
        end else begin
            c.mode = MODE_UNUSED;
        end
        return c;
    endfunction

    task automatic add_cfg(input logic [rfo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfo_pkg::CFG_DATA_W-1:0] data);
        t_stim_row r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        directed_rows.push_back(r);
    endtask

    task automatic add_item(input logic [rfo_pkg::MODE_W-1:0] mode,
                            input logic [rfo_pkg::KIND_W-1:0] kind,
                            input logic [rfo_pkg::COORD_W-1:0] left,
                            input logic [rfo_pkg::COORD_W-1:0] top,
                            input logic [rfo_pkg::COORD_W-1:0] sx,
                            input logic [rfo_pkg::COORD_W-1:0] sy,
                            input logic [rfo_pkg::CODE_W-1:0] code,
                            input logic [rfo_pkg::RC_W-1:0] col,
                            input logic [rfo_pkg::RC_W-1:0] row, input logic fixed,
                            input logic [rfo_pkg::STATUS_W-1:0] st,
                            input logic [rfo_pkg::CODE_W-1:0] px);
        t_stim_row r;
        r                = '0;
        r.item.mode      = mode;
        r.item.kind      = kind;
        r.item.left      = left;
        r.item.top       = top;
        r.item.size_x    = sx;
        r.item.size_y    = sy;
        r.item.fill_code = code;
        r.item.read_col  = col;
        r.item.read_row  = row;
        r.fixed          = fixed;
        r.typed.status   = st;
        r.typed.pixel    = px;
        directed_rows.push_back(r);
    endtask

    // Offer one item, hold it until taken, then queue its expected result
    task automatic send_item(input t_rect_cmd c, input logic fixed, input t_pix_res typed);
        t_pix_res predicted;
        while (int'($urandom_range(99)) < send_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.mode      <= c.mode;
        cmd_ch.kind      <= c.kind;
        cmd_ch.left      <= c.left;
        cmd_ch.top       <= c.top;
        cmd_ch.size_x    <= c.size_x;
        cmd_ch.size_y    <= c.size_y;
        cmd_ch.fill_code <= c.fill_code;
        cmd_ch.read_col  <= c.read_col;
        cmd_ch.read_row  <= c.read_row;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predicted = predict_result(c);
        expected_results.push_back(fixed ? typed : predicted);
    endtask

    task automatic write_reg(input logic [rfo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rfo_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            rfo_pkg::REG_WIDTH:      cfg_width  = data[rfo_pkg::DIM_W-1:0];
            rfo_pkg::REG_HEIGHT:     cfg_height = data[rfo_pkg::DIM_W-1:0];
            rfo_pkg::REG_BACKGROUND: cfg_bg     = data[rfo_pkg::CODE_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: check each accepted item, then pick the next ready
    initial begin
        t_pix_res want;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result status %0d pixel %0h with none expected",
                                              res_ch.status, res_ch.pixel));
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  res_ch.status, want.status));
                    if (res_ch.pixel !== want.pixel)
                        report_mismatch($sformatf("pixel got %0h want %0h",
                                                  res_ch.pixel, want.pixel));
                end
            end
            res_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_rect_cmd c;
        t_stim_row r;
        int        cols, rows;
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.mode      <= '0;
        cmd_ch.kind      <= '0;
        cmd_ch.left      <= '0;
        cmd_ch.top       <= '0;
        cmd_ch.size_x    <= '0;
        cmd_ch.size_y    <= '0;
        cmd_ch.fill_code <= '0;
        cmd_ch.read_col  <= '0;
        cmd_ch.read_row  <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;

        // Directed rows: register defaults, rejects, extremes, outline, saturation, empty area
        add_item(rfo_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, rfo_pkg::RST_BACKGROUND);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 1, 0,
                 1, rfo_pkg::ST_OUTSIDE, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 511,
                 1, rfo_pkg::ST_OUTSIDE, 8'h00);
        add_item(MODE_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 8'hFF, 511, 511, 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, rfo_pkg::KIND_FILLED, 0, 0, 24'h000000, 24'h000100,
                 8'h21, 0, 0, 1, rfo_pkg::ST_REJECT, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, rfo_pkg::KIND_OUTLINE, 0, 0, 24'h000100, 24'h800000,
                 8'h22, 0, 0, 1, rfo_pkg::ST_REJECT, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, 8'h00, 0, 0, 24'h000100, 24'h000100, 8'h23, 0, 0,
                 1, rfo_pkg::ST_REJECT, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, 8'hFF, 0, 0, 24'h000100, 24'h000100, 8'h24, 0, 0,
                 1, rfo_pkg::ST_REJECT, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, rfo_pkg::KIND_FILLED, 0, 0, 24'h7FFFFF, 24'h7FFFFF,
                 8'hAA, 0, 0, 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, 8'hAA);
        add_cfg(rfo_pkg::REG_BACKGROUND, 10'h3FF);
        add_cfg(rfo_pkg::REG_WIDTH, 10'd8);
        add_cfg(rfo_pkg::REG_HEIGHT, 10'd4);
        add_item(rfo_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 7, 3,
                 1, rfo_pkg::ST_OK, 8'hFF);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 8, 3,
                 1, rfo_pkg::ST_OUTSIDE, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, rfo_pkg::KIND_OUTLINE, 24'h000180, 24'h000080,
                 24'h000500, 24'h000280, 8'h55, 0, 0, 0, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 2, 1,
                 0, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 3, 2,
                 0, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, rfo_pkg::KIND_FILLED, 24'h800000, 0, 24'h7FFFFF,
                 24'h7FFFFF, 8'h11, 0, 0, 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, 8'hFF);
        add_cfg(rfo_pkg::REG_WIDTH, 10'd1023);
        add_cfg(rfo_pkg::REG_HEIGHT, 10'd1);
        add_cfg(rfo_pkg::REG_BACKGROUND, 10'h000);
        add_item(rfo_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 511, 0,
                 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_DRAW, rfo_pkg::KIND_FILLED, 24'h01FE00, 0, 24'h000100,
                 24'h000100, 8'hC3, 0, 0, 0, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 511, 0,
                 0, rfo_pkg::ST_OK, 8'h00);
        add_cfg(rfo_pkg::REG_WIDTH, 10'd0);
        add_cfg(rfo_pkg::REG_HEIGHT, 10'd7);
        add_item(rfo_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OK, 8'h00);
        add_item(rfo_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                 1, rfo_pkg::ST_OUTSIDE, 8'h00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows; registers change only once the block is idle
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.is_cfg) begin
                settle();
                write_reg(r.reg_idx, r.reg_data);
            end else begin
                send_item(r.item, r.fixed, r.typed);
            end
        end

        // Random phases, each opened by a clear so every readable pixel is written
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            send_gap_pct   = phase_send[p];
            recv_stall_pct = phase_recv[p];
            write_reg(rfo_pkg::REG_WIDTH, rfo_pkg::CFG_DATA_W'(phase_cols[p]));
            write_reg(rfo_pkg::REG_HEIGHT, rfo_pkg::CFG_DATA_W'(phase_rows[p]));
            write_reg(rfo_pkg::REG_BACKGROUND, rfo_pkg::CFG_DATA_W'(phase_bg[p]));
            cols = clamp_extent(cfg_width, TB_COLS);
            rows = clamp_extent(cfg_height, TB_ROWS);
            c      = '0;
            c.mode = rfo_pkg::MODE_CLEAR;
            send_item(c, 1'b0, '0);
            for (int n = 0; n < phase_len[p]; n++)
                send_item(make_item(cols, rows, cols * rows <= 8192), 1'b0, '0);
        end

        // Drain, then give stray results time to show up
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* rectangle_fill_outline_rasterizer_unit.f */
rtl/rfo_pkg.sv
rtl/rfo_ifs.sv
rtl/rfo_ram.sv
rtl/rectangle_fill_outline_rasterizer_unit.sv
tb/tb_rectangle_fill_outline_rasterizer_unit.sv
